/* src/u8d_pkg.sv */
// Package with shared widths, status codes and types for the UTF-8 decoder.
`timescale 1ns / 1ps

package u8d_pkg;

   // Field widths of the byte and code point channels.
   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int CP_PAD  = 24;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 2;

   // Status codes carried with every code point.
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_BADLEAD = 2'd1;
   localparam logic [STAT_W-1:0] ST_BROKEN = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE  = 2'd3;

   // Outcome of decoding one byte.
   typedef struct packed {
      logic              emit;
      logic [CP_W-1:0]   code_point;
      logic [STAT_W-1:0] status;
   } u8d_result_type;

endpackage

/* src/u8d_in_stage.sv */
// Input register that holds one byte request until the decoder takes it.
`timescale 1ns / 1ps

module u8d_in_stage
   import u8d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              advance,
   output logic              byte_valid,
   output logic [BYTE_W-1:0] byte_value
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;

   // The register may be refilled in the same cycle that it is drained.
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         data_in  = req_tdata;
      end
   end

   // Control state is reset; the data register is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_value = data_ff;

endmodule

/* src/u8d_decode.sv */
// Decoder state and the single-pass logic that turns one byte into a result.
`timescale 1ns / 1ps

module u8d_decode
   import u8d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [BYTE_W-1:0] byte_value,
   output u8d_result_type    result
);

   logic [CP_W-1:0]    partial_ff;
   logic [CP_W-1:0]    partial_in;
   logic [COUNT_W-1:0] remaining_ff;
   logic [COUNT_W-1:0] remaining_in;
   logic [CP_W-1:0]    shifted;
   logic [CP_W-1:0]    byte_wide;

   assign shifted   = {partial_ff[CP_W-7:0], byte_value[5:0]};
   assign byte_wide = {{(CP_W-BYTE_W){1'b0}}, byte_value};

   // Next state and result for the byte now presented.
   always_comb begin
      partial_in        = partial_ff;
      remaining_in      = remaining_ff;
      result.emit       = 1'b0;
      result.code_point = byte_wide;
      result.status     = ST_OK;
      if (remaining_ff != '0) begin
         if (byte_value[7:6] == 2'b10) begin
            // Continuation byte: shift in six payload bits.
            partial_in        = shifted;
            remaining_in      = remaining_ff - 1'b1;
            result.code_point = shifted;
            result.emit       = (remaining_ff == 2'd1);
         end else begin
            // Sequence broken: drop the partial value, pass the byte on.
            partial_in    = '0;
            remaining_in  = '0;
            result.emit   = 1'b1;
            result.status = ST_BROKEN;
         end
      end else begin
         if (byte_value inside {[8'h00:8'h7F]}) begin
            result.emit = 1'b1;
         end else if (byte_value inside {[8'hC0:8'hDF]}) begin
            partial_in   = {{(CP_W-5){1'b0}}, byte_value[4:0]};
            remaining_in = 2'd1;
         end else if (byte_value inside {[8'hE0:8'hEF]}) begin
            partial_in   = {{(CP_W-4){1'b0}}, byte_value[3:0]};
            remaining_in = 2'd2;
         end else if (byte_value inside {[8'hF0:8'hF4]}) begin
            partial_in   = {{(CP_W-3){1'b0}}, byte_value[2:0]};
            remaining_in = 2'd3;
         end else if (byte_value inside {[8'hF5:8'hF7]}) begin
            // Lead beyond the code space: error with a zero code point.
            result.emit       = 1'b1;
            result.code_point = '0;
            result.status     = ST_RANGE;
         end else begin
            // Lone continuation byte or a byte of 0xF8 and above.
            result.emit   = 1'b1;
            result.status = ST_BADLEAD;
         end
      end
   end

   // State moves only when a byte is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         remaining_ff <= '0;
      end else if (advance) begin
         partial_ff   <= partial_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

/* src/u8d_out_stage.sv */
// Result register that presents one code point to the downstream side.
`timescale 1ns / 1ps

module u8d_out_stage
   import u8d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  u8d_result_type      result,
   output logic                can_accept,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [CP_PAD-1:0]   rsp_tdata,
   output logic [STAT_W-1:0]   rsp_tuser
);

   logic              valid_ff;
   logic              valid_in;
   logic [CP_W-1:0]   cp_ff;
   logic [CP_W-1:0]   cp_in;
   logic [STAT_W-1:0] status_ff;
   logic [STAT_W-1:0] status_in;

   // Free when empty or when the held result leaves this cycle.
   assign can_accept = !valid_ff || rsp_tready;

   always_comb begin
      valid_in  = valid_ff && !rsp_tready;
      cp_in     = cp_ff;
      status_in = status_ff;
      if (advance && result.emit) begin
         valid_in  = 1'b1;
         cp_in     = result.code_point;
         status_in = result.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff     <= cp_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(CP_PAD-CP_W){1'b0}}, cp_ff};
   assign rsp_tuser  = status_ff;

endmodule

/* src/utf8_to_codepoint_decoder.sv */
// Top level of the streaming UTF-8 to code point decoder.
//
//   Channel  Direction  Payload
//   req_     in         tdata[7:0] byte_in
//   rsp_     out        tdata[20:0] code_point, tuser[1:0] status
//
// One byte is taken per clock when the result side is not stalled; a result
// is presented once its final byte has waited in the input register and been
// decoded into the result register. Reset is synchronous and clears the
// sequence state and both valid flags. A stall on rsp_tready holds the result
// register, and the input register then takes at most one more byte before
// req_tready drops.
`timescale 1ns / 1ps

module utf8_to_codepoint_decoder
   import u8d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] byte_in
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CP_PAD-1:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [STAT_W-1:0] rsp_tuser    // [1:0] status
);

   logic              byte_valid;
   logic [BYTE_W-1:0] byte_value;
   logic              can_accept;
   logic              advance;
   u8d_result_type    result;

   // A byte is decoded when one is held and the result register is free.
   assign advance = byte_valid && can_accept;

   u8d_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_value (byte_value)
   );

   u8d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .byte_value (byte_value),
      .result     (result)
   );

   u8d_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .result     (result),
      .can_accept (can_accept),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // No result is shown in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A range error always carries a zero code point.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_RANGE) |-> (rsp_tdata == '0))
      else $error("range error with non-zero code point");

   // An invalid lead is a continuation byte or a byte of 0xF8 and above.
   a_badlead_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_BADLEAD) |->
      (rsp_tdata[CP_PAD-1:8] == '0 &&
       (rsp_tdata[7:6] == 2'b10 || rsp_tdata[7:3] == 5'b11111)))
      else $error("invalid lead status with unexpected byte");

   // No code point ever exceeds the largest value a 0xF4 lead can build.
   a_cp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= 24'h13FFFF))
      else $error("code point out of range");
`endif

endmodule
